// File: sv/civ_pkg.sv
// Shared types, constants and constant functions of the cell current model.
package civ_pkg;

  localparam int VOLTAGE_WIDTH = 16;
  localparam int CURRENT_WIDTH = 32;
  localparam int COND_W        = 16;
  localparam int CFG_W         = 16;
  localparam int LOG_FRAC      = 24;
  localparam int LOG_INT       = 5;
  localparam int LOG_W         = LOG_INT + LOG_FRAC;
  localparam int MANT_W        = 32;
  localparam int QUO_W         = 32;
  localparam int MAG_W         = 64;
  localparam int GV_W          = COND_W + VOLTAGE_WIDTH;
  localparam int DEN_W         = ((VOLTAGE_WIDTH > CFG_W) ? VOLTAGE_WIDTH : CFG_W) + 1;
  localparam int NUM_W         = DEN_W + QUO_W;

  localparam logic [1:0] REG_IV_MODE = 2'd0;
  localparam logic [1:0] REG_VREF    = 2'd1;
  localparam logic [1:0] REG_ALPHA   = 2'd2;
  localparam logic [1:0] REG_VSAT    = 2'd3;

  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_POWER  = 2'd1;
  localparam logic [1:0] MODE_SOFT   = 2'd2;

  typedef struct packed {
    logic signed [VOLTAGE_WIDTH-1:0] cell_voltage;
    logic [COND_W-1:0]               cell_conductance;
  } in_item_t;

  typedef struct packed {
    logic signed [CURRENT_WIDTH-1:0] cell_curr;
    logic                            overflow;
  } out_item_t;

  // truncating integer square root, elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = x_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (b > x) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 64'd0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // Q1.31 value of 2^(2^-k), built as a chain of truncated roots
  function automatic logic [31:0] exp2_root(input int k);
    logic [63:0] c;
    c = isqrt64(64'h8000_0000_0000_0000);
    for (int j = 1; j < k; j++) begin
      c = isqrt64(c << 31);
    end
    return c[31:0];
  endfunction

endpackage

// File: sv/civ_delay.sv
// Fixed-depth shift line that keeps side data aligned with the pipeline.
module civ_delay #(
  parameter int W = 8,
  parameter int D = 4
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sh_r [0:D-1];

  always_ff @(posedge clk) begin
    sh_r[0] <= d;
    for (int i = 1; i < D; i++) begin
      sh_r[i] <= sh_r[i-1];
    end
  end

  assign q = sh_r[D-1];

endmodule

// File: sv/civ_log2.sv
// Pipelined log2: normalize stage, then one mantissa squaring per stage.
module civ_log2 #(
  parameter int IN_W = 16
) (
  input  logic                      clk,
  input  logic [IN_W-1:0]           x,
  output logic [civ_pkg::LOG_W-1:0] lg
);

  localparam int SQ = civ_pkg::LOG_FRAC;
  localparam int MW = civ_pkg::MANT_W;

  logic [civ_pkg::LOG_INT-1:0] e_r  [0:SQ];
  logic [MW-1:0]               m_r  [0:SQ];
  logic [SQ-1:0]               fr_r [0:SQ];

  logic [MW-1:0]               xw;
  logic [MW-1:0]               norm;
  logic [civ_pkg::LOG_INT-1:0] msb;

  always_comb begin
    xw  = MW'(x);
    msb = '0;
    for (int i = 0; i < MW; i++) begin
      if (xw[i]) msb = civ_pkg::LOG_INT'(i);
    end
    norm = xw << (civ_pkg::LOG_INT'(MW - 1) - msb);
  end

  always_ff @(posedge clk) begin
    e_r[0]  <= msb;
    m_r[0]  <= norm;
    fr_r[0] <= '0;
  end

  for (genvar k = 0; k < SQ; k++) begin : g_sq
    logic [2*MW-1:0] sq;
    logic [MW:0]     q;
    assign sq = (2*MW)'(m_r[k]) * (2*MW)'(m_r[k]);
    assign q  = sq[2*MW-1:MW-1];
    always_ff @(posedge clk) begin
      e_r[k+1] <= e_r[k];
      if (q[MW]) begin
        m_r[k+1]  <= q[MW:1];
        fr_r[k+1] <= {fr_r[k][SQ-2:0], 1'b1};
      end else begin
        m_r[k+1]  <= q[MW-1:0];
        fr_r[k+1] <= {fr_r[k][SQ-2:0], 1'b0};
      end
    end
  end

  assign lg = {e_r[SQ], fr_r[SQ]};

endmodule

// File: sv/civ_exp2.sv
// Pipelined 2^f for a Q.24 fraction: one conditional root product per stage.
module civ_exp2 (
  input  logic                         clk,
  input  logic [civ_pkg::LOG_FRAC-1:0] f,
  output logic [civ_pkg::MANT_W-1:0]   p
);

  localparam int SQ = civ_pkg::LOG_FRAC;
  localparam int MW = civ_pkg::MANT_W;
  localparam logic [MW-1:0] ONE = MW'(1) << (MW - 1);

  logic [MW-1:0] p_r [1:SQ];
  logic [SQ-1:0] f_r [1:SQ];

  for (genvar k = 1; k <= SQ; k++) begin : g_st
    localparam logic [MW-1:0] C = civ_pkg::exp2_root(k);
    logic [MW-1:0]   p_in;
    logic [SQ-1:0]   f_in;
    logic [2*MW-1:0] prod;
    if (k == 1) begin : g_first
      assign p_in = ONE;
      assign f_in = f;
    end else begin : g_next
      assign p_in = p_r[k-1];
      assign f_in = f_r[k-1];
    end
    assign prod = (2*MW)'(p_in) * (2*MW)'(C);
    always_ff @(posedge clk) begin
      p_r[k] <= f_in[SQ-k] ? prod[2*MW-2:MW-1] : p_in;
      f_r[k] <= f_in;
    end
  end

  assign p = p_r[SQ];

endmodule

// File: sv/civ_div.sv
// Pipelined restoring divider, one quotient bit per stage, MSB first.
module civ_div #(
  parameter int XW = 65,
  parameter int DW = 17,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic [XW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [XW-1:0] rem_r [1:QW];
  logic [DW-1:0] d_r   [1:QW];
  logic [QW-1:0] q_r   [1:QW];

  for (genvar k = 1; k <= QW; k++) begin : g_st
    logic [XW-1:0] rem_in;
    logic [XW-1:0] dsh;
    logic [DW-1:0] d_in;
    logic [QW-1:0] q_in;
    logic          ge;
    if (k == 1) begin : g_first
      assign rem_in = num;
      assign d_in   = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign d_in   = d_r[k-1];
      assign q_in   = q_r[k-1];
    end
    assign dsh = XW'(d_in) << (QW - k);
    assign ge  = rem_in >= dsh;
    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? (rem_in - dsh) : rem_in;
      d_r[k]   <= d_in;
      q_r[k]   <= {q_in[QW-2:0], ge};
    end
  end

  assign quo = q_r[QW];

endmodule

// File: sv/cell_iv_current_model.sv
// Cell current: linear, power-law or soft-saturation law, fully pipelined.
// Throughput: one item per cycle; busy stays low, results cannot be held off.
// Depth is set by the power law: 24 log2 squaring stages and 24 exp2 product stages.
// Reset (synchronous, rst_n low) clears the valid pipeline and restores the registers
// to linear mode with reference, exponent and knee at 1.0.
module cell_iv_current_model (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  civ_pkg::in_item_t   in_data,
  output logic                out_valid,
  output civ_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_idx,
  input  logic [civ_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int VW     = civ_pkg::VOLTAGE_WIDTH;
  localparam int CW     = civ_pkg::CURRENT_WIDTH;
  localparam int GW     = civ_pkg::COND_W;
  localparam int FW     = civ_pkg::CFG_W;
  localparam int LW     = civ_pkg::LOG_W;
  localparam int MAGW   = civ_pkg::MAG_W;
  localparam int PROD_W = FW + LW + 2;
  localparam int T_W    = PROD_W - 10;
  localparam int LAT    = 54;
  localparam int VLD_D  = 52;
  localparam logic signed [T_W-1:0] N_HI = T_W'(CW - 1);
  // below this exponent the rounded result is zero
  localparam logic signed [T_W-1:0] N_LO = T_W'(-9);

  // configuration
  logic [1:0]    mode_r;
  logic [FW-1:0] vref_r, alpha_r, vsat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= civ_pkg::MODE_LINEAR;
      vref_r  <= FW'(4096);
      alpha_r <= FW'(4096);
      vsat_r  <= FW'(4096);
    end else if (cfg_we) begin
      case (cfg_idx)
        civ_pkg::REG_IV_MODE: mode_r  <= cfg_wdata[1:0];
        civ_pkg::REG_VREF:    vref_r  <= cfg_wdata;
        civ_pkg::REG_ALPHA:   alpha_r <= cfg_wdata;
        civ_pkg::REG_VSAT:    vsat_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [FW-1:0] vref_eff, vsat_eff;
  assign vref_eff = (vref_r == '0) ? FW'(1) : vref_r;
  assign vsat_eff = (vsat_r == '0) ? FW'(1) : vsat_r;

  assign busy = 1'b0;

  // stage A: sign/magnitude split
  logic [VW-1:0] vraw, vabs_c;
  logic          neg_c;
  assign vraw   = in_data.cell_voltage;
  assign neg_c  = vraw[VW-1];
  assign vabs_c = neg_c ? (~vraw + VW'(1)) : vraw;

  logic          a_vld_r;
  logic [VW-1:0] a_vabs_r;
  logic [GW-1:0] a_g_r;
  logic          a_neg_r, a_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else        a_vld_r <= start && !busy;
    a_vabs_r <= vabs_c;
    a_g_r    <= in_data.cell_conductance;
    a_neg_r  <= neg_c;
    a_zero_r <= (vabs_c == '0) || (in_data.cell_conductance == '0);
  end

  // valid bits travel alongside the data
  logic vld_r [1:VLD_D];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= VLD_D; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[1] <= a_vld_r;
      for (int i = 2; i <= VLD_D; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  logic [1:0] flg_d;
  civ_delay #(.W(2), .D(VLD_D)) u_flg_dly (
    .clk(clk), .d({a_neg_r, a_zero_r}), .q(flg_d)
  );

  // power law: log domain
  logic [LW-1:0] lv, lr, lg;
  civ_log2 #(.IN_W(VW)) u_log_v (.clk(clk), .x(a_vabs_r), .lg(lv));
  civ_log2 #(.IN_W(FW)) u_log_r (.clk(clk), .x(vref_eff), .lg(lr));
  civ_log2 #(.IN_W(GW)) u_log_g (.clk(clk), .x(a_g_r),    .lg(lg));

  logic signed [LW:0]       diff;
  logic signed [PROD_W-1:0] p1_prod_r;
  logic [LW:0]              p1_base_r;
  assign diff = $signed({1'b0, lv}) - $signed({1'b0, lr});

  always_ff @(posedge clk) begin
    p1_prod_r <= $signed({1'b0, alpha_r}) * diff;
    p1_base_r <= (LW+1)'(lg) + (LW+1)'(lr);
  end

  logic signed [T_W-1:0] t_c, n_c;
  assign t_c = $signed(T_W'(p1_prod_r >>> 12)) + $signed(T_W'(p1_base_r));
  assign n_c = t_c >>> civ_pkg::LOG_FRAC;

  logic [civ_pkg::LOG_FRAC-1:0] p2_f_r;
  logic [7:0]                   p2_n_r;
  logic                         p2_big_r, p2_tiny_r;

  always_ff @(posedge clk) begin
    p2_f_r    <= t_c[civ_pkg::LOG_FRAC-1:0];
    p2_n_r    <= n_c[7:0];
    p2_big_r  <= n_c >= N_HI;
    p2_tiny_r <= n_c < N_LO;
  end

  logic [civ_pkg::MANT_W-1:0] exp_p;
  civ_exp2 u_exp (.clk(clk), .f(p2_f_r), .p(exp_p));

  logic [9:0] p2_d;
  civ_delay #(.W(10), .D(civ_pkg::LOG_FRAC)) u_pow_dly (
    .clk(clk), .d({p2_n_r, p2_big_r, p2_tiny_r}), .q(p2_d)
  );

  logic signed [7:0] pn, sl;
  logic [5:0]        amt_l, amt_r;
  logic [MAGW-1:0]   pw, pmag_c;

  always_comb begin
    pn    = $signed(p2_d[9:2]);
    sl    = pn - 8'sd31;
    amt_l = sl[5:0];
    amt_r = 6'(8'sd31 - pn);
    pw    = MAGW'(exp_p);
    if (!sl[7]) pmag_c = pw << amt_l;
    else        pmag_c = (pw + (MAGW'(1) << (amt_r - 6'd1))) >> amt_r;
    if (p2_d[1] || p2_d[0]) pmag_c = '0;
  end

  logic [MAGW-1:0] p3_mag_r;
  logic            p3_big_r;
  always_ff @(posedge clk) begin
    p3_mag_r <= pmag_c;
    p3_big_r <= p2_d[1];
  end

  // linear product and soft-saturation quotient
  logic [civ_pkg::GV_W-1:0]      m1_gv_r;
  logic [civ_pkg::DEN_W-1:0]     m1_den_r, m2_den_r, m3_den_r;
  logic [civ_pkg::GV_W+FW-1:0]   m2_num_r;
  logic [civ_pkg::NUM_W-1:0]     m3_num_r;

  always_ff @(posedge clk) begin
    m1_gv_r  <= civ_pkg::GV_W'(a_g_r) * civ_pkg::GV_W'(a_vabs_r);
    m1_den_r <= civ_pkg::DEN_W'(vsat_eff) + civ_pkg::DEN_W'(a_vabs_r);
    m2_num_r <= (civ_pkg::GV_W+FW)'(m1_gv_r) * (civ_pkg::GV_W+FW)'(vsat_eff);
    m2_den_r <= m1_den_r;
    m3_num_r <= civ_pkg::NUM_W'(m2_num_r) + civ_pkg::NUM_W'(m2_den_r >> 1);
    m3_den_r <= m2_den_r;
  end

  logic [civ_pkg::QUO_W-1:0] soft_q, soft_d;
  civ_div #(.XW(civ_pkg::NUM_W), .DW(civ_pkg::DEN_W), .QW(civ_pkg::QUO_W)) u_div (
    .clk(clk), .num(m3_num_r), .den(m3_den_r), .quo(soft_q)
  );
  civ_delay #(.W(civ_pkg::QUO_W), .D(17)) u_soft_dly (
    .clk(clk), .d(soft_q), .q(soft_d)
  );

  logic [civ_pkg::GV_W-1:0] lin_d;
  civ_delay #(.W(civ_pkg::GV_W), .D(51)) u_lin_dly (
    .clk(clk), .d(m1_gv_r), .q(lin_d)
  );

  // select, saturate, sign
  logic [MAGW-1:0] mag, lim, magsat, res;
  logic            povf, ovf;

  always_comb begin
    case (mode_r)
      civ_pkg::MODE_POWER: begin
        mag  = p3_mag_r;
        povf = p3_big_r;
      end
      civ_pkg::MODE_SOFT: begin
        mag  = MAGW'(soft_d);
        povf = 1'b0;
      end
      default: begin
        mag  = MAGW'(lin_d);
        povf = 1'b0;
      end
    endcase
    if (flg_d[0]) begin
      mag  = '0;
      povf = 1'b0;
    end
    lim    = flg_d[1] ? (MAGW'(1) << (CW - 1)) : ((MAGW'(1) << (CW - 1)) - MAGW'(1));
    ovf    = povf || (mag > lim);
    magsat = ovf ? lim : mag;
    res    = flg_d[1] ? (MAGW'(0) - magsat) : magsat;
  end

  logic                out_valid_r;
  civ_pkg::out_item_t  out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= vld_r[VLD_D];
    out_data_r.cell_curr <= $signed(res[CW-1:0]);
    out_data_r.overflow  <= ovf;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted item did not produce a result on time");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result without an accepted item");

  a_ovf_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.overflow) |->
      ((out_data.cell_curr == {1'b0, {(CW-1){1'b1}}}) ||
       (out_data.cell_curr == {1'b1, {(CW-1){1'b0}}})))
    else $error("overflow flagged without a clamped current");

  a_zero_v: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.cell_voltage == '0)) |->
      ##LAT (out_data.cell_curr == '0 && !out_data.overflow))
    else $error("zero voltage gave nonzero current");

endmodule
